// ===== rtl/core/tick_count_to_nanoseconds_macros.svh =====
// Assertion helpers for the tick count to nanoseconds block.
// Every macro samples on aclk; the user supplies label, antecedent,
// consequent and the message string.
`ifndef TICK_COUNT_TO_NANOSECONDS_MACROS_SVH
`define TICK_COUNT_TO_NANOSECONDS_MACROS_SVH

// Same-cycle implication, off while in reset.
`define TC2NS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define TC2NS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked through reset.
`define TC2NS_ASSERT_NEXT_ALL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tc2ns_pkg.sv =====
`default_nettype none

package tc2ns_pkg;

    // Conversion constants
    localparam int unsigned        NS_SCALE_BITS = 30;
    localparam logic [29:0]        NS_PER_SEC    = 30'd1000000000;
    localparam int unsigned        SECS_W        = 35;
    // floor((2^64 - 1) / 1e9): largest whole-second count that still fits
    localparam logic [34:0]        SECS_MAX      = 35'd18446744073;

    // Register map: 64-bit registers at 8-byte spacing
    localparam int unsigned        REG_IDX_W     = 1;
    localparam int unsigned        PADDR_W       = REG_IDX_W + 3;
    localparam logic [REG_IDX_W-1:0] REG_TICK_FREQUENCY = 1'd0;
    localparam logic [63:0]        TICK_FREQUENCY_RST = 64'd1000000000;

    // Long-division stage payload
    typedef struct packed {
        logic [63:0] rem;   // partial remainder, below the frequency
        logic [63:0] cq;    // unused dividend bits on top, quotient bits below
    } div_t;

    // Fraction-scaling stage payload
    typedef struct packed {
        logic [63:0] acc;   // scaled residue, below the frequency
        logic [63:0] rem;   // division remainder being scaled
        logic [29:0] q;     // fraction nanoseconds so far
        logic [34:0] secs;  // whole seconds, valid when big is clear
        logic        big;   // whole seconds out of range
    } scl_t;

endpackage

`default_nettype wire

// ===== rtl/core/tick_count_to_nanoseconds.sv =====
`default_nettype none

// Converts a 64-bit free-running tick count into nanoseconds as
// floor(tick_count * 1e9 / tick_frequency), with the frequency set over the
// APB port (64-bit register at address 0, reset value 1e9, read back at any
// time). One transfer is taken every cycle unless a result waits on m_ready;
// each result passes, in order, through 129 register stages: one input
// register, a 64-stage restoring divider that yields whole seconds and
// remainder one quotient bit per stage, 61 stages of shift-and-subtract
// scaling of the remainder (a capture stage, then a doubling step and an add
// step per bit of 1e9), a partial-product multiply of the seconds by 1e9, a
// recombine stage and the output register. The whole pipeline holds while a
// result waits on m_ready, so s_ready drops in exactly those cycles.
// A zero frequency, a seconds count above floor((2^64-1)/1e9), or a final sum
// that overflows 64 bits returns all ones with m_saturated set; an exact
// result of 2^64-1 comes back with m_saturated clear. The frequency may only
// be rewritten while the pipeline is empty, since the divider and scaler read it live.

module tick_count_to_nanoseconds (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input channel
    input  wire logic                             s_valid,
    output      logic                             s_ready,
    input  wire logic [63:0]                      s_tick_count,
    // result channel
    output      logic                             m_valid,
    input  wire logic                             m_ready,
    output      logic [63:0]                      m_nanoseconds,
    output      logic                             m_saturated,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tc2ns_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [63:0]                      pwdata,
    output      logic [63:0]                      prdata,
    output      logic                             pready
);

    localparam int unsigned DIV_STAGES = 64;
    localparam int unsigned SCL_STAGES = 2 * tc2ns_pkg::NS_SCALE_BITS;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [63:0]                         tick_frequency_reg;
    logic [tc2ns_pkg::REG_IDX_W-1:0]     reg_idx;
    logic                                cfg_wr;

    assign reg_idx = paddr[tc2ns_pkg::PADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_frequency_reg <= tc2ns_pkg::TICK_FREQUENCY_RST;
        end else if (cfg_wr && (reg_idx == tc2ns_pkg::REG_TICK_FREQUENCY)) begin
            tick_frequency_reg <= pwdata;
        end
    end

    assign prdata = (reg_idx == tc2ns_pkg::REG_TICK_FREQUENCY) ? tick_frequency_reg : 64'd0;

    // ------------------------------------------------------------------
    // Global advance: every stage moves together unless the output
    // register holds a result that is not being taken.
    // ------------------------------------------------------------------
    logic en;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    logic [64:0] freq_ext;
    assign freq_ext = {1'b0, tick_frequency_reg};

    // ------------------------------------------------------------------
    // Divider: stage 0 captures the count, stage k has produced k
    // quotient bits, MSB first.
    // ------------------------------------------------------------------
    tc2ns_pkg::div_t div_reg  [0:DIV_STAGES];
    tc2ns_pkg::div_t div_next [1:DIV_STAGES];
    logic            div_v_reg [0:DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg[0].rem <= 64'd0;
            div_reg[0].cq  <= s_tick_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_v_reg[0] <= 1'b0;
        end else if (en) begin
            div_v_reg[0] <= s_valid;
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        logic [64:0] r2;
        logic [64:0] diff;
        logic        ge;

        assign r2   = {div_reg[k-1].rem, div_reg[k-1].cq[63]};
        assign ge   = (r2 >= freq_ext);
        assign diff = r2 - freq_ext;

        always_comb begin
            div_next[k].rem = ge ? diff[63:0] : r2[63:0];
            div_next[k].cq  = {div_reg[k-1].cq[62:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[k] <= div_next[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_v_reg[k] <= 1'b0;
            end else if (en) begin
                div_v_reg[k] <= div_v_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Fraction scaler: floor(rem * 1e9 / freq) without a wide product.
    // Odd stages double the residue, even stages add rem where the
    // matching bit of 1e9 is set; each reduces modulo freq once.
    // ------------------------------------------------------------------
    tc2ns_pkg::scl_t scl_reg  [0:SCL_STAGES];
    tc2ns_pkg::scl_t scl_next [0:SCL_STAGES];
    logic            scl_v_reg [0:SCL_STAGES];

    logic [63:0] quo;
    assign quo = div_reg[DIV_STAGES].cq;

    always_comb begin
        scl_next[0].acc  = 64'd0;
        scl_next[0].rem  = div_reg[DIV_STAGES].rem;
        scl_next[0].q    = '0;
        scl_next[0].secs = quo[tc2ns_pkg::SECS_W-1:0];
        scl_next[0].big  = (quo[63:tc2ns_pkg::SECS_W] != '0)
                        || (quo[tc2ns_pkg::SECS_W-1:0] > tc2ns_pkg::SECS_MAX);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            scl_reg[0] <= scl_next[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scl_v_reg[0] <= 1'b0;
        end else if (en) begin
            scl_v_reg[0] <= div_v_reg[DIV_STAGES];
        end
    end

    for (genvar j = 1; j <= SCL_STAGES; j++) begin : g_scl
        localparam int unsigned BIT     = tc2ns_pkg::NS_SCALE_BITS - 1 - (j - 1) / 2;
        localparam bit          DBL     = ((j % 2) == 1);
        localparam bit          ADD_REM = tc2ns_pkg::NS_PER_SEC[BIT];

        if (DBL) begin : g_dbl
            logic [64:0] a2;
            logic [64:0] diff;
            logic        ge;

            assign a2   = {scl_reg[j-1].acc, 1'b0};
            assign ge   = (a2 >= freq_ext);
            assign diff = a2 - freq_ext;

            always_comb begin
                scl_next[j]     = scl_reg[j-1];
                scl_next[j].acc = ge ? diff[63:0] : a2[63:0];
                scl_next[j].q   = {scl_reg[j-1].q[28:0], ge};
            end
        end else if (ADD_REM) begin : g_add
            logic [64:0] s;
            logic [64:0] diff;
            logic        ge;

            assign s    = {1'b0, scl_reg[j-1].acc} + {1'b0, scl_reg[j-1].rem};
            assign ge   = (s >= freq_ext);
            assign diff = s - freq_ext;

            always_comb begin
                scl_next[j]     = scl_reg[j-1];
                scl_next[j].acc = ge ? diff[63:0] : s[63:0];
                scl_next[j].q   = scl_reg[j-1].q + 30'(ge);
            end
        end else begin : g_pass
            // zero bit of 1e9: nothing to add
            assign scl_next[j] = scl_reg[j-1];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                scl_reg[j] <= scl_next[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                scl_v_reg[j] <= 1'b0;
            end else if (en) begin
                scl_v_reg[j] <= scl_v_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Seconds times 1e9 as two partial products, then recombine.
    // ------------------------------------------------------------------
    logic [61:0] pp_lo_reg;
    logic [31:0] pp_hi_reg;
    logic [29:0] mul_q_reg;
    logic        mul_big_reg;
    logic        mul_v_reg;

    logic [61:0] pp_lo_next;
    logic [31:0] pp_hi_next;

    assign pp_lo_next = 62'(scl_reg[SCL_STAGES].secs[31:0]) * 62'(tc2ns_pkg::NS_PER_SEC);
    assign pp_hi_next = 32'(scl_reg[SCL_STAGES].secs[34:32]) * 32'(tc2ns_pkg::NS_PER_SEC);

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
            mul_q_reg   <= scl_reg[SCL_STAGES].q;
            mul_big_reg <= scl_reg[SCL_STAGES].big;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg <= 1'b0;
        end else if (en) begin
            mul_v_reg <= scl_v_reg[SCL_STAGES];
        end
    end

    logic [63:0] whole_reg;
    logic [63:0] whole_next;
    logic [29:0] whl_q_reg;
    logic        whl_big_reg;
    logic        whl_v_reg;

    // no carry out: seconds are in range whenever big is clear
    assign whole_next = {2'b00, pp_lo_reg} + {pp_hi_reg, 32'd0};

    always_ff @(posedge aclk) begin
        if (en) begin
            whole_reg   <= whole_next;
            whl_q_reg   <= mul_q_reg;
            whl_big_reg <= mul_big_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            whl_v_reg <= 1'b0;
        end else if (en) begin
            whl_v_reg <= mul_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Final add, saturation and output register
    // ------------------------------------------------------------------
    logic [64:0] sum;
    logic        sat;
    logic [63:0] m_nanoseconds_reg;
    logic [63:0] m_nanoseconds_next;
    logic        m_saturated_reg;

    assign sum = {1'b0, whole_reg} + 65'(whl_q_reg);
    assign sat = (tick_frequency_reg == 64'd0) || whl_big_reg || sum[64];
    assign m_nanoseconds_next = sat ? '1 : sum[63:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            m_nanoseconds_reg <= m_nanoseconds_next;
            m_saturated_reg   <= sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= whl_v_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_nanoseconds = m_nanoseconds_reg;
    assign m_saturated   = m_saturated_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tc2ns_checker.sv =====
`default_nettype none

`include "tick_count_to_nanoseconds_macros.svh"

module tc2ns_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_ready,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic [63:0]                      m_nanoseconds,
    input wire logic                             m_saturated,
    input wire logic                             psel,
    input wire logic                             penable,
    input wire logic                             pwrite,
    input wire logic [tc2ns_pkg::PADDR_W-1:0]    paddr,
    input wire logic [63:0]                      pwdata,
    input wire logic [63:0]                      prdata,
    input wire logic                             pready
);

    logic freq_sel;
    logic freq_wr;
    assign freq_sel = (paddr[tc2ns_pkg::PADDR_W-1:3] == tc2ns_pkg::REG_TICK_FREQUENCY);
    assign freq_wr  = psel && penable && pwrite && pready && freq_sel;

    // saturated results always read as all ones
    `TC2NS_ASSERT_NOW(a_sat_all_ones, m_valid && m_saturated, m_nanoseconds == '1, "saturated result not all ones")

    // pipeline freezes as a whole while a result waits
    `TC2NS_ASSERT_NOW(a_stall_blocks_input, m_valid && !m_ready, !s_ready, "input taken during output stall")

    // a waiting result holds still
    `TC2NS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_nanoseconds) && $stable(m_saturated), "stalled result changed")

    // written frequency reads back while the address still selects it
    `TC2NS_ASSERT_NEXT(a_freq_readback, freq_wr, !freq_sel || (prdata == $past(pwdata)), "frequency readback mismatch")

    // pipeline empties on reset
    `TC2NS_ASSERT_NEXT_ALL(a_reset_empty, !aresetn, !m_valid, "result valid right after reset")

endmodule

bind tick_count_to_nanoseconds tc2ns_checker u_tc2ns_checker (.*);

`default_nettype wire

// ===== dv/tick_count_to_nanoseconds_tb.sv =====
module tick_count_to_nanoseconds_tb;

    // Conversion constants, kept local to the bench
    localparam logic [63:0] NS_PER_S      = 64'd1000000000;
    localparam logic [63:0] SECS_LIMIT    = 64'd18446744073;   // floor((2^64-1)/1e9)
    localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

    // Register map: one 64-bit register at byte 0, index 1 lands on byte 8
    localparam logic [tc2ns_pkg::PADDR_W-1:0] FREQ_ADDR     = 'd0;
    localparam logic [tc2ns_pkg::PADDR_W-1:0] UNMAPPED_ADDR = 'd8;

    // Pipeline is 129 deep; the hold-off is long enough to back it up fully
    localparam int LATENCY        = 129;
    localparam int TAIL_CYCLES    = 2 * LATENCY;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_MODE = 14;
    localparam int BURST_ITEMS    = 150;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [63:0] ns;
        logic        sat;
    } ns_result_t;

    // Expected-result store plus the conversion predictor
    class ns_scoreboard;
        ns_result_t  ns_expected[$];
        logic [63:0] freq;
        int          errors;

        function new();
            freq   = NS_PER_S;
            errors = 0;
        endfunction

        // floor(count * 1e9 / freq) in 128 bits; anything past 64 bits saturates
        function ns_result_t predict_ns(logic [63:0] count);
            ns_result_t  r;
            logic [127:0] scaled;
            logic [127:0] quot;
            r.ns  = ALL_ONES;
            r.sat = 1'b1;
            if (freq != 0) begin
                scaled = {64'd0, count} * {64'd0, NS_PER_S};
                quot   = scaled / {64'd0, freq};
                if (quot[127:64] == 0) begin
                    r.ns  = quot[63:0];
                    r.sat = 1'b0;
                end
            end
            return r;
        endfunction

        function void note_tick_count(logic [63:0] count);
            ns_expected.push_back(predict_ns(count));
        endfunction

        function void check_nanoseconds(logic [63:0] ns, logic sat);
            ns_result_t e;
            if (ns_expected.size() == 0) begin
                $error("nanoseconds: no transfer pending, got %0d (saturated %0b)", ns, sat);
                errors++;
                return;
            end
            e = ns_expected.pop_front();
            if (ns !== e.ns) begin
                $error("nanoseconds: expected %0d, got %0d", e.ns, ns);
                errors++;
            end
            if (sat !== e.sat) begin
                $error("saturated: expected %0b, got %0b", e.sat, sat);
                errors++;
            end
        endfunction

        function int pending();
            return ns_expected.size();
        endfunction
    endclass

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    always #1 aclk = ~aclk;

    // Block inputs, all known from time zero
    logic                          s_valid      = 1'b0;
    logic [63:0]                   s_tick_count = '0;
    logic                          m_ready      = 1'b0;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [tc2ns_pkg::PADDR_W-1:0] paddr        = '0;
    logic [63:0]                   pwdata       = '0;

    // Block outputs
    logic        s_ready;
    logic        m_valid;
    logic [63:0] m_nanoseconds;
    logic        m_saturated;
    logic [63:0] prdata;
    logic        pready;

    tick_count_to_nanoseconds dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_tick_count  (s_tick_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_nanoseconds (m_nanoseconds),
        .m_saturated   (m_saturated),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    ns_scoreboard sb;

    // Idle knobs shared by the sender task and the receiver process
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_pending   = 1'b0;   // main asks, receiver process counts it out
    int quiet_cycles   = 0;

    // Monitor and watchdog. Sampling at the edge sees pre-edge values on both
    // sides, so a transfer is seen exactly when the block sees it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_tick_count(s_tick_count);
            end
            if (m_valid && m_ready) begin
                sb.check_nanoseconds(m_nanoseconds, m_saturated);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    // Receiver: random stalls per cycle, or a long hold-off when asked for.
    // The hold-off keeps m_ready low while the sender keeps pushing, so the
    // pipeline backs up and s_ready drops.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_left    = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND: begin
                send_idle_pct  = 63;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct  = 0;
                recv_stall_pct = 63;
            end
            default: begin
                send_idle_pct  = 14;
                recv_stall_pct = 14;
            end
        endcase
    endtask

    // One input transfer. Valid stays up across back-to-back items; it only
    // drops when the sender decides to idle.
    task automatic send_count(logic [63:0] count);
        s_valid      <= 1'b1;
        s_tick_count <= count;
        do @(posedge aclk); while (!s_ready);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Stop offering and wait for every expected result. The first edge lets
    // the monitor note a transfer taken at the edge we were called on.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(logic [tc2ns_pkg::PADDR_W-1:0] addr, logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only index 0 exists; other writes are dropped
        if (addr == FREQ_ADDR) begin
            sb.freq = data;
        end
    endtask

    task automatic apb_read_check();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= FREQ_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== sb.freq) begin
            $error("tick_frequency: expected %0d, got %0d", sb.freq, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Count mix: full range, shifted-down values, sparse-bit values, near all
    // ones, near multiples of the frequency, and near the whole-second limit
    // where the overflow cases live.
    function automatic logic [63:0] pick_count(logic [63:0] f);
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: pick_count = r;
            1: pick_count = r >> $urandom_range(0, 63);
            2: pick_count = ALL_ONES - 64'($urandom_range(0, 1000));
            3: pick_count = f * 64'({$urandom} >> $urandom_range(0, 31))
                            + 64'($urandom_range(0, 3));
            4: pick_count = f * SECS_LIMIT + f - 64'd1 - 64'($urandom_range(0, 3));
            default: pick_count = r & {$urandom, $urandom};
        endcase
    endfunction

    initial begin : main
        logic [63:0] freq_plan[10];
        sb = new();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset frequency is 1e9, so counts come back unchanged
        set_idle(IDLE_NONE);
        apb_read_check();
        send_count(64'd0);
        send_count(64'd1);
        send_count(NS_PER_S - 1);
        send_count(NS_PER_S);
        send_count(ALL_ONES);                      // true result exactly 2^64-1, no flag
        send_count(64'h5555_5555_5555_5555);
        send_count(64'hAAAA_AAAA_AAAA_AAAA);
        drain();

        // One tick per second: whole seconds at and just past the limit
        apb_write(FREQ_ADDR, 64'd1);
        send_count(SECS_LIMIT);
        send_count(SECS_LIMIT + 1);
        send_count(ALL_ONES);
        drain();

        // Four ticks per second: seconds at the limit, fraction tips the sum over
        apb_write(FREQ_ADDR, 64'd4);
        send_count(4 * SECS_LIMIT + 3);
        send_count(4 * SECS_LIMIT + 2);
        drain();

        // Zero frequency always saturates
        apb_write(FREQ_ADDR, 64'd0);
        send_count(64'd0);
        send_count(ALL_ONES);
        send_count(64'd12345);
        drain();

        // Write to a nonexistent register must leave the frequency alone
        apb_write(UNMAPPED_ADDR, 64'd7);
        apb_read_check();
        send_count(NS_PER_S);
        drain();

        // Random phases over a spread of frequencies, extremes included
        freq_plan[0] = ALL_ONES;
        freq_plan[1] = 64'd0;
        freq_plan[2] = 64'd1;
        freq_plan[3] = 64'd3;
        freq_plan[4] = 64'($urandom_range(1, 1000));
        freq_plan[5] = {32'd0, $urandom};
        freq_plan[6] = {$urandom, $urandom};
        freq_plan[7] = 64'h8000_0000_0000_0000;
        freq_plan[8] = {$urandom, $urandom} >> $urandom_range(1, 40);
        freq_plan[9] = NS_PER_S;

        for (int p = 0; p < 10; p++) begin
            drain();
            apb_write(FREQ_ADDR, freq_plan[p]);
            apb_read_check();
            for (int m = 0; m < 4; m++) begin
                set_idle(idle_mode_t'(m));
                for (int i = 0; i < ITEMS_PER_MODE; i++) begin
                    send_count(pick_count(sb.freq));
                end
            end
            // Back-pressure burst: receiver holds off while the sender streams
            if (p == 6) begin
                set_idle(IDLE_NONE);
                hold_pending = 1'b1;
                for (int i = 0; i < BURST_ITEMS; i++) begin
                    send_count(pick_count(sb.freq));
                end
                // sender pauses until everything is back, then resumes
                drain();
                for (int i = 0; i < ITEMS_PER_MODE; i++) begin
                    send_count(pick_count(sb.freq));
                end
            end
        end

        set_idle(IDLE_NONE);
        drain();
        // Catch any stray result beyond the last expected one
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
